// ===== hdl/vic_pkg.sv =====
// shared constants, codes and types for the vectored interrupt controller
package vic_pkg;

	localparam int NUM_LINES = 64;
	localparam int LINE_W    = 6;
	localparam int DATA_W    = 64;
	localparam int ACT_W     = 3;
	localparam int SEL_W     = 3;
	localparam int STRIDE_SH = 3;

	localparam logic [DATA_W-1:0] LINE_MASK = {DATA_W{1'b1}} >> (DATA_W - NUM_LINES);
	localparam logic [LINE_W:0]   NUM_LINES_L = (LINE_W + 1)'(NUM_LINES);

	// control word bits
	localparam int CTRL_GEN_BIT  = 0;
	localparam int CTRL_NEST_BIT = 1;

	// actions
	localparam logic [ACT_W-1:0] ACT_RAISE = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd1;
	localparam logic [ACT_W-1:0] ACT_READ  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_WRITE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_POLL  = 3'd4;

	// register selects
	localparam logic [SEL_W-1:0] SEL_PEND = 3'd0;
	localparam logic [SEL_W-1:0] SEL_EN   = 3'd1;
	localparam logic [SEL_W-1:0] SEL_CTRL = 3'd2;
	localparam logic [SEL_W-1:0] SEL_BASE = 3'd3;
	localparam logic [SEL_W-1:0] SEL_CUR  = 3'd4;
	localparam logic [SEL_W-1:0] SEL_ACK  = 3'd5;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [LINE_W-1:0] line;
		logic [SEL_W-1:0]  reg_select;
		logic [DATA_W-1:0] write_data;
	} item_t;

	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              served;
		logic [LINE_W-1:0] served_line;
		logic [DATA_W-1:0] vector_address;
	} result_t;

	typedef struct packed {
		logic              valid;
		logic [LINE_W-1:0] line;
	} isv_status_t;

endpackage

// ===== hdl/vic_prio_enc.sv =====
// lowest-set-bit priority encoder over the interrupt lines
module vic_prio_enc (
	input  logic [vic_pkg::DATA_W-1:0] active,
	output logic                       found,
	output logic [vic_pkg::LINE_W-1:0] idx
);
	import vic_pkg::*;

	logic [DATA_W-1:0] onehot;

	always_comb begin
		// isolate the lowest set bit, then encode it
		onehot = active & (~active + DATA_W'(1));
		found  = |active;
		idx    = '0;
		for (int i = 0; i < DATA_W; i++) begin
			if (onehot[i]) begin
				idx = idx | LINE_W'(i);
			end
		end
	end

endmodule

// ===== hdl/vic_state.sv =====
// controller registers and the single-pass handling of one word
module vic_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  vic_pkg::item_t       item,
	output vic_pkg::result_t     res,
	output vic_pkg::isv_status_t isv
);
	import vic_pkg::*;

	logic [DATA_W-1:0] pend_q, en_q, ctrl_q, base_q;
	logic [DATA_W-1:0] pend_d, en_d, ctrl_d, base_d;
	logic              isv_valid_q, isv_valid_d;
	logic [LINE_W-1:0] isv_line_q, isv_line_d;
	logic [DATA_W-1:0] active;
	logic              found;
	logic [LINE_W-1:0] idx;
	logic              line_ok;
	logic              poll_gate;

	assign active = pend_q & en_q & LINE_MASK;

	vic_prio_enc u_prio (
		.active (active),
		.found  (found),
		.idx    (idx)
	);

	assign line_ok   = {1'b0, item.line} < NUM_LINES_L;
	assign poll_gate = ctrl_q[CTRL_GEN_BIT] && (!isv_valid_q || ctrl_q[CTRL_NEST_BIT]);

	always_comb begin
		pend_d      = pend_q;
		en_d        = en_q;
		ctrl_d      = ctrl_q;
		base_d      = base_q;
		isv_valid_d = isv_valid_q;
		isv_line_d  = isv_line_q;
		res         = '0;
		case (item.action)
			ACT_RAISE: begin
				if (line_ok) pend_d[item.line] = 1'b1;
			end
			ACT_CLEAR: begin
				if (line_ok) pend_d[item.line] = 1'b0;
			end
			ACT_READ: begin
				unique case (item.reg_select)
					SEL_PEND: res.read_data = pend_q;
					SEL_EN:   res.read_data = en_q;
					SEL_CTRL: res.read_data = ctrl_q;
					SEL_BASE: res.read_data = base_q;
					SEL_CUR:  res.read_data = isv_valid_q ? DATA_W'(isv_line_q) : '1;
					default:  res.read_data = '0;
				endcase
			end
			ACT_WRITE: begin
				unique case (item.reg_select)
					SEL_PEND: pend_d = pend_q & ~item.write_data;
					SEL_EN:   en_d   = item.write_data;
					SEL_CTRL: ctrl_d = item.write_data;
					SEL_BASE: base_d = item.write_data;
					SEL_ACK: begin
						if (isv_valid_q && item.write_data == DATA_W'(isv_line_q))
							isv_valid_d = 1'b0;
					end
					default: ;
				endcase
			end
			ACT_POLL: begin
				if (poll_gate && found) begin
					isv_valid_d        = 1'b1;
					isv_line_d         = idx;
					pend_d[idx]        = 1'b0;
					res.served         = 1'b1;
					res.served_line    = idx;
					res.vector_address = base_q + (DATA_W'(idx) << STRIDE_SH);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			en_q        <= '0;
			ctrl_q      <= '0;
			base_q      <= '0;
			isv_valid_q <= 1'b0;
			isv_line_q  <= '0;
		end else if (adv) begin
			pend_q      <= pend_d;
			en_q        <= en_d;
			ctrl_q      <= ctrl_d;
			base_q      <= base_d;
			isv_valid_q <= isv_valid_d;
			isv_line_q  <= isv_line_d;
		end
	end

	assign isv.valid = isv_valid_q;
	assign isv.line  = isv_line_q;

endmodule

// ===== hdl/vectored_interrupt_controller_core.sv =====
// top level of the vectored interrupt controller: input stage, state, result register
//
//  channel  | direction | tdata                                   | tuser
//  ---------+-----------+-----------------------------------------+------------------------
//  s_*      | in        | line, write_data                        | action, reg_select
//  m_*      | out       | read_data, served_line, vector_address  | served
//
// one word per cycle sustained while m_tready stays high; a word taken sits in the input register
// and moves on into the result register once that register can take it, where its result is offered
// the 64-line lowest-bit search and the vector add sit between those two registers
// arst_n clears all controller registers: nothing pending, enabled or in service
// a stalled result register holds the input stage, which then holds s_tready low
module vectored_interrupt_controller_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [71:0]  s_tdata,   // line[5:0], write_data[69:6], zero pad
	input  logic [5:0]   s_tuser,   // action[2:0], reg_select[5:3]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,   // read_data[63:0], served_line[69:64],
	                                // vector_address[133:70], zero pad
	output logic [0:0]   m_tuser    // served
);
	import vic_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	logic        adv;
	logic        out_valid_q;
	result_t     out_res_q;
	result_t     res;
	isv_status_t isv;

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.action     <= s_tuser[2:0];
			item_s1.reg_select <= s_tuser[5:3];
			item_s1.line       <= s_tdata[5:0];
			item_s1.write_data <= s_tdata[69:6];
		end
	end

	vic_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.item   (item_s1),
		.res    (res),
		.isv    (isv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) out_res_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_res_q.vector_address, out_res_q.served_line,
	                   out_res_q.read_data};
	assign m_tuser  = out_res_q.served;

`ifndef NO_ASSERTIONS
	// a word leaving the input stage always lands in the result register
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid)
		else $error("result register empty after a word advanced");

	// input stage only refuses while it holds a word
	a_ready_low_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1)
		else $error("s_tready low with an empty input stage");

	// a served poll leaves that line in service
	a_serve_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.served) |=> (isv.valid && isv.line == $past(res.served_line)))
		else $error("served line not marked in service");

	// no result without a word
	a_out_from_adv: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(adv))
		else $error("result appeared without a word advancing");
`endif

endmodule
